@@ hdl/ansi_escape_key_decoder_assert.svh @@
// Assertion macros for the key decoder port checker.
// Depends on nothing; included by the checker file.
`ifndef ANSI_ESCAPE_KEY_DECODER_ASSERT_SVH
`define ANSI_ESCAPE_KEY_DECODER_ASSERT_SVH

// same-cycle implication, masked during reset
`define AEKD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key decoder assertion failed");

// next-cycle implication, masked during reset
`define AEKD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key decoder assertion failed");

// same-cycle implication, also checked around reset
`define AEKD_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("key decoder assertion failed");

`endif

@@ hdl/aekd_pkg.sv @@
// Types, character and key codes, and key lookup functions of the key decoder.
// Depends on nothing; used by every other .sv file of the design and testbench.
`timescale 1ns / 1ps

package aekd_pkg;

   typedef logic [4:0] key_type;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_SEQ    = 2'd2;

   localparam logic [2:0] SEQ_LIMIT = 3'd7;
   localparam logic [2:0] OVERLONG  = 3'd6;

   localparam logic [15:0] SCAN_CODE_ESC = 16'h0017;

   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_O        = 8'h4F;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_ONE      = 8'h31;
   localparam logic [7:0] CH_TWO      = 8'h32;

   localparam key_type KEY_NONE   = 5'h00;
   localparam key_type KEY_UP     = 5'h01;
   localparam key_type KEY_DOWN   = 5'h02;
   localparam key_type KEY_RIGHT  = 5'h03;
   localparam key_type KEY_LEFT   = 5'h04;
   localparam key_type KEY_HOME   = 5'h05;
   localparam key_type KEY_END    = 5'h06;
   localparam key_type KEY_INSERT = 5'h07;
   localparam key_type KEY_DELETE = 5'h08;
   localparam key_type KEY_PGUP   = 5'h09;
   localparam key_type KEY_PGDN   = 5'h0A;
   localparam key_type KEY_F1     = 5'h0B;
   localparam key_type KEY_F2     = 5'h0C;
   localparam key_type KEY_F3     = 5'h0D;
   localparam key_type KEY_F4     = 5'h0E;
   localparam key_type KEY_F5     = 5'h0F;
   localparam key_type KEY_F6     = 5'h10;
   localparam key_type KEY_F7     = 5'h11;
   localparam key_type KEY_F8     = 5'h12;
   localparam key_type KEY_F9     = 5'h13;
   localparam key_type KEY_F10    = 5'h14;
   localparam key_type KEY_F11    = 5'h15;
   localparam key_type KEY_F12    = 5'h16;

   typedef struct packed {
      logic [1:0]      mode;
      logic [2:0][7:0] bytes;
      logic [2:0]      len;
      logic            pend;
   } state_type;

   typedef struct packed {
      logic        handle_key;
      logic [15:0] out_scan_code;
      logic [15:0] out_char;
      logic        escape_pending;
   } result_type;

   function automatic key_type letter_key(input logic [7:0] c, input logic ss3);
      key_type k;
      case (c)
         8'h41:   k = KEY_UP;
         8'h42:   k = KEY_DOWN;
         8'h43:   k = KEY_RIGHT;
         8'h44:   k = KEY_LEFT;
         8'h48:   k = KEY_HOME;
         8'h46:   k = KEY_END;
         8'h50:   k = ss3 ? KEY_F1 : KEY_NONE;
         8'h51:   k = ss3 ? KEY_F2 : KEY_NONE;
         8'h52:   k = ss3 ? KEY_F3 : KEY_NONE;
         8'h53:   k = ss3 ? KEY_F4 : KEY_NONE;
         default: k = KEY_NONE;
      endcase
      return k;
   endfunction

   function automatic key_type tilde1_key(input logic [7:0] c);
      key_type k;
      case (c)
         8'h31, 8'h37: k = KEY_HOME;
         8'h32:        k = KEY_INSERT;
         8'h33:        k = KEY_DELETE;
         8'h34, 8'h38: k = KEY_END;
         8'h35:        k = KEY_PGUP;
         8'h36:        k = KEY_PGDN;
         default:      k = KEY_NONE;
      endcase
      return k;
   endfunction

   function automatic key_type tilde2_key(input logic [7:0] lead, input logic [7:0] c);
      key_type k;
      if (lead == CH_ONE) begin
         case (c)
            8'h30:   k = KEY_F10;
            8'h31:   k = KEY_F1;
            8'h32:   k = KEY_F2;
            8'h33:   k = KEY_F3;
            8'h34:   k = KEY_F4;
            8'h35:   k = KEY_F5;
            8'h37:   k = KEY_F6;
            8'h38:   k = KEY_F7;
            8'h39:   k = KEY_F8;
            default: k = KEY_NONE;
         endcase
      end else begin
         case (c)
            8'h30:   k = KEY_F9;
            8'h31:   k = KEY_F10;
            8'h33:   k = KEY_F11;
            8'h34:   k = KEY_F12;
            default: k = KEY_NONE;
         endcase
      end
      return k;
   endfunction

endpackage

@@ hdl/aekd_step.sv @@
// Combinational parser step: current state and one key event in,
// next state and the result out. Depends on aekd_pkg.
`timescale 1ns / 1ps

module aekd_step
   import aekd_pkg::*;
(
   input  state_type   cur_state,
   input  logic [15:0] scan_code,
   input  logic [15:0] unicode_char,
   output state_type   nxt_state,
   output result_type  result
);

   logic            bare_esc;
   logic            pass;
   key_type         key;
   logic [2:0][7:0] bytes_upd;
   logic [2:0]      len_upd;

   assign bare_esc = (scan_code == SCAN_CODE_ESC) && (unicode_char == 16'd0);

   always_comb begin
      nxt_state = cur_state;
      key       = KEY_NONE;
      pass      = 1'b0;
      bytes_upd = cur_state.bytes;
      len_upd   = cur_state.len + 3'd1;
      if (cur_state.len < 3'd3) begin
         bytes_upd[cur_state.len[1:0]] = unicode_char[7:0];
      end

      if (cur_state.mode == MODE_NORMAL && !bare_esc) begin
         pass = 1'b1;
      end else if (bare_esc) begin
         nxt_state.mode  = MODE_ESC;
         nxt_state.len   = 3'd0;
         nxt_state.bytes = '0;
         nxt_state.pend  = 1'b1;
      end else if (scan_code != 16'd0 || unicode_char == 16'd0) begin
         nxt_state.mode = MODE_NORMAL;
      end else if (cur_state.mode == MODE_ESC) begin
         if (unicode_char == {8'd0, CH_LBRACKET}) begin
            nxt_state.mode = MODE_SEQ;
         end else if (unicode_char == {8'd0, CH_O}) begin
            nxt_state.mode     = MODE_SEQ;
            nxt_state.bytes[0] = CH_O;
            nxt_state.len      = 3'd1;
         end else begin
            nxt_state.mode = MODE_NORMAL;
         end
      end else if (cur_state.mode != MODE_SEQ || cur_state.len >= SEQ_LIMIT) begin
         nxt_state.mode = MODE_NORMAL;
      end else begin
         nxt_state.bytes = bytes_upd;
         nxt_state.len   = len_upd;
         if (len_upd == 3'd1 && bytes_upd[0] != CH_O) begin
            key = letter_key(bytes_upd[0], 1'b0);
            if (key != KEY_NONE) begin
               nxt_state.mode = MODE_NORMAL;
               nxt_state.pend = 1'b0;
            end
         end else if (len_upd == 3'd2 && bytes_upd[1] == CH_TILDE) begin
            nxt_state.mode = MODE_NORMAL;
            nxt_state.pend = 1'b0;
            key            = tilde1_key(bytes_upd[0]);
         end else if (len_upd == 3'd3 && (bytes_upd[0] == CH_ONE || bytes_upd[0] == CH_TWO)
                      && bytes_upd[2] == CH_TILDE) begin
            nxt_state.mode = MODE_NORMAL;
            nxt_state.pend = 1'b0;
            key            = tilde2_key(bytes_upd[0], bytes_upd[1]);
         end else if (len_upd == 3'd2 && bytes_upd[0] == CH_O) begin
            nxt_state.mode = MODE_NORMAL;
            nxt_state.pend = 1'b0;
            key            = letter_key(bytes_upd[1], 1'b1);
         end else if (len_upd >= OVERLONG) begin
            nxt_state.mode = MODE_NORMAL;
         end
      end
   end

   always_comb begin
      result.handle_key     = pass || (key != KEY_NONE);
      result.out_scan_code  = (key != KEY_NONE) ? {11'd0, key} : scan_code;
      result.out_char       = (key != KEY_NONE) ? 16'd0 : unicode_char;
      result.escape_pending = nxt_state.pend;
   end

endmodule

@@ hdl/ansi_escape_key_decoder.sv @@
// Path: an accepted request is registered in the input register, then its parsed result
// in the result register, which drives the rsp outputs.
// Throughput: one key event per cycle unless the receiver stalls rsp; the parser state
// updates as an event moves from the input register into the result register.
// Reset: synchronous, active high; clears both valid flags and returns the
// parser to normal mode with empty sequence bytes and no pending escape.
`timescale 1ns / 1ps

module ansi_escape_key_decoder
   import aekd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_scan_code,
   input  logic [15:0] req_unicode_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_handle_key,
   output logic [15:0] rsp_out_scan_code,
   output logic [15:0] rsp_out_char,
   output logic        rsp_escape_pending
);

   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_scan_ff;
   logic [15:0] in_char_ff;
   state_type   state_ff, state_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   result_type  step_result;
   logic        advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   aekd_step u_step (
      .cur_state    (state_ff),
      .scan_code    (in_scan_ff),
      .unicode_char (in_char_ff),
      .nxt_state    (state_in),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_scan_ff <= req_scan_code;
         in_char_ff <= req_unicode_char;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_handle_key     = out_ff.handle_key;
   assign rsp_out_scan_code  = out_ff.out_scan_code;
   assign rsp_out_char       = out_ff.out_char;
   assign rsp_escape_pending = out_ff.escape_pending;

endmodule

@@ hdl/aekd_checker.sv @@
// Port-level checker for ansi_escape_key_decoder, bound into the decoder module.
// Depends on aekd_pkg and ansi_escape_key_decoder_assert.svh.
`timescale 1ns / 1ps
`include "ansi_escape_key_decoder_assert.svh"

module aekd_checker
   import aekd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_handle_key,
   input logic [15:0] rsp_out_scan_code,
   input logic [15:0] rsp_out_char,
   input logic        rsp_escape_pending
);

   logic        rsp_bare_esc;
   logic        rsp_esc_held;
   logic [33:0] rsp_payload;

   assign rsp_bare_esc = (rsp_out_scan_code == SCAN_CODE_ESC) && (rsp_out_char == 16'd0);
   assign rsp_esc_held = rsp_valid && !rsp_handle_key && rsp_bare_esc;
   assign rsp_payload  = {rsp_handle_key, rsp_out_scan_code, rsp_out_char, rsp_escape_pending};

   `AEKD_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset), !rsp_valid)
   `AEKD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `AEKD_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `AEKD_ASSERT_NOW(a_bare_esc_pends, clock, reset, rsp_esc_held, rsp_escape_pending)

endmodule

bind ansi_escape_key_decoder aekd_checker u_aekd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_handle_key     (rsp_handle_key),
   .rsp_out_scan_code  (rsp_out_scan_code),
   .rsp_out_char       (rsp_out_char),
   .rsp_escape_pending (rsp_escape_pending)
);

@@ dv/key_result_checker.sv @@
// Checker for the key decoder: watches both channels, predicts each result
// from its own copy of the parser state and compares field by field.
// Depends on aekd_pkg for the result type and the key and character codes.
`timescale 1ns / 1ps

module key_result_checker
   import aekd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_scan_code,
   input  logic [15:0] req_unicode_char,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_handle_key,
   input  logic [15:0] rsp_out_scan_code,
   input  logic [15:0] rsp_out_char,
   input  logic        rsp_escape_pending,
   output int          mismatches,
   output int          outstanding,
   output int          checked,
   output int          decoded
);

   logic [1:0] parse_state = MODE_NORMAL;
   logic [7:0] seq_buf [3] = '{default: 8'h00};
   logic [2:0] seq_count   = 3'd0;
   logic       esc_waiting = 1'b0;
   result_type expected_results[$];
   int         fail_total    = 0;
   int         checked_total = 0;
   int         decoded_total = 0;

   // final letter of CSI or SS3; F1-F4 only after SS3
   function automatic key_type letter_final(input logic [7:0] c, input logic ss3);
      key_type k;
      k = KEY_NONE;
      case (c)
         "A": k = KEY_UP;
         "B": k = KEY_DOWN;
         "C": k = KEY_RIGHT;
         "D": k = KEY_LEFT;
         "H": k = KEY_HOME;
         "F": k = KEY_END;
         "P", "Q", "R", "S": begin
            if (ss3) k = key_type'(KEY_F1 + (c - "P"));
         end
         default: k = KEY_NONE;
      endcase
      return k;
   endfunction

   function automatic key_type tilde_short(input logic [7:0] d);
      key_type k;
      case (d)
         "1", "7": k = KEY_HOME;
         "2":      k = KEY_INSERT;
         "3":      k = KEY_DELETE;
         "4", "8": k = KEY_END;
         "5":      k = KEY_PGUP;
         "6":      k = KEY_PGDN;
         default:  k = KEY_NONE;
      endcase
      return k;
   endfunction

   function automatic key_type tilde_long(input logic [7:0] lead, input logic [7:0] d);
      key_type k;
      k = KEY_NONE;
      if (lead == CH_ONE) begin
         if (d >= "1" && d <= "5") k = key_type'(KEY_F1 + (d - "1"));
         else if (d >= "7" && d <= "9") k = key_type'(KEY_F6 + (d - "7"));
         else if (d == "0") k = KEY_F10;
      end else begin
         if (d == "0" || d == "1") k = key_type'(KEY_F9 + (d - "0"));
         else if (d == "3" || d == "4") k = key_type'(KEY_F11 + (d - "3"));
      end
      return k;
   endfunction

   task automatic decode_key_event(input logic [15:0] sc, input logic [15:0] ch,
                                   output result_type res);
      key_type k;
      logic    bare_esc;
      k = KEY_NONE;
      bare_esc = (sc == SCAN_CODE_ESC) && (ch == 16'h0000);
      res.handle_key    = 1'b0;
      res.out_scan_code = sc;
      res.out_char      = ch;
      if (parse_state == MODE_NORMAL && !bare_esc) begin
         res.handle_key = 1'b1;
      end else if (bare_esc) begin
         parse_state = MODE_ESC;
         seq_count   = 3'd0;
         seq_buf     = '{default: 8'h00};
         esc_waiting = 1'b1;
      end else if (sc != 16'h0000 || ch == 16'h0000) begin
         parse_state = MODE_NORMAL;
      end else if (parse_state == MODE_ESC) begin
         if (ch == {8'h00, CH_LBRACKET}) begin
            parse_state = MODE_SEQ;
         end else if (ch == {8'h00, CH_O}) begin
            parse_state = MODE_SEQ;
            seq_buf[0]  = CH_O;
            seq_count   = 3'd1;
         end else begin
            parse_state = MODE_NORMAL;
         end
      end else if (parse_state != MODE_SEQ || seq_count >= SEQ_LIMIT) begin
         parse_state = MODE_NORMAL;
      end else begin
         if (seq_count < 3'd3) seq_buf[seq_count] = ch[7:0];
         seq_count = seq_count + 3'd1;
         if (seq_count == 3'd1 && seq_buf[0] != CH_O) begin
            k = letter_final(seq_buf[0], 1'b0);
            if (k != KEY_NONE) begin
               parse_state = MODE_NORMAL;
               esc_waiting = 1'b0;
            end
         end else if (seq_count == 3'd2 && seq_buf[1] == CH_TILDE) begin
            parse_state = MODE_NORMAL;
            esc_waiting = 1'b0;
            k = tilde_short(seq_buf[0]);
         end else if (seq_count == 3'd3 && (seq_buf[0] == CH_ONE || seq_buf[0] == CH_TWO)
                      && seq_buf[2] == CH_TILDE) begin
            parse_state = MODE_NORMAL;
            esc_waiting = 1'b0;
            k = tilde_long(seq_buf[0], seq_buf[1]);
         end else if (seq_count == 3'd2 && seq_buf[0] == CH_O) begin
            parse_state = MODE_NORMAL;
            esc_waiting = 1'b0;
            k = letter_final(seq_buf[1], 1'b1);
         end else if (seq_count >= OVERLONG) begin
            parse_state = MODE_NORMAL;
         end
      end
      if (k != KEY_NONE) begin
         res.handle_key    = 1'b1;
         res.out_scan_code = {11'b0, k};
         res.out_char      = 16'h0000;
         decoded_total++;
      end
      res.escape_pending = esc_waiting;
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      fail_total++;
      if (fail_total <= 40)
         $display("mismatch on %s at %0t ns: got %h expected %h", what, $time, got, want);
   endtask

   always @(posedge clock) begin
      result_type predicted;
      result_type want;
      if (reset) begin
         parse_state = MODE_NORMAL;
         seq_buf     = '{default: 8'h00};
         seq_count   = 3'd0;
         esc_waiting = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no event waiting", rsp_out_scan_code, 16'h0000);
            end else begin
               want = expected_results.pop_front();
               checked_total++;
               if (rsp_handle_key !== want.handle_key)
                  report_mismatch("handle_key", 16'(rsp_handle_key), 16'(want.handle_key));
               if (rsp_out_scan_code !== want.out_scan_code)
                  report_mismatch("out_scan_code", rsp_out_scan_code, want.out_scan_code);
               if (rsp_out_char !== want.out_char)
                  report_mismatch("out_char", rsp_out_char, want.out_char);
               if (rsp_escape_pending !== want.escape_pending)
                  report_mismatch("escape_pending", 16'(rsp_escape_pending),
                                  16'(want.escape_pending));
            end
         end
         if (req_valid && req_ready) begin
            decode_key_event(req_scan_code, req_unicode_char, predicted);
            expected_results.push_back(predicted);
         end
      end
      outstanding <= expected_results.size();
      mismatches  <= fail_total;
      checked     <= checked_total;
      decoded     <= decoded_total;
   end

endmodule

@@ dv/tb.sv @@
// Top of the key decoder testbench: clock, reset, key event stimulus and the
// receiver stall pattern. Depends on aekd_pkg, ansi_escape_key_decoder and
// key_result_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb
   import aekd_pkg::*;
();

   localparam int EVENT_TARGET = 2000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [15:0] req_scan_code    = 16'h0000;
   logic [15:0] req_unicode_char = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic        rsp_handle_key;
   logic [15:0] rsp_out_scan_code;
   logic [15:0] rsp_out_char;
   logic        rsp_escape_pending;

   int mismatches;
   int outstanding;
   int checked;
   int decoded;
   int cycles      = 0;
   int sent        = 0;
   int burst_left  = 0;
   int stall_phase = 0;
   bit paused_mid  = 1'b0;

   always #2 clock = ~clock;

   ansi_escape_key_decoder dut (.*);

   key_result_checker result_check (.*);

   // receiver: full rate, coin flip, periodic ready, mostly stalled
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 256) % 4)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 1) == 1);
         2:       rsp_ready <= (stall_phase % 3 == 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_event(input logic [15:0] sc, input logic [15:0] ch);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_valid        <= 1'b1;
      req_scan_code    <= sc;
      req_unicode_char <= ch;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // characters of a sequence body; may be broken up by non-character events
   task automatic send_text(input string s, input bit interrupt);
      logic [7:0] hi;
      for (int i = 0; i < s.len(); i++) begin
         if (interrupt && $urandom_range(0, 7) == 0)
            send_event(16'($urandom_range(0, 24)), 16'h0000);
         hi = ($urandom_range(0, 31) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
         send_event(16'h0000, {hi, s[i]});
      end
   endtask

   function automatic string pick(input string set);
      int i;
      i = $urandom_range(0, set.len() - 1);
      return set.substr(i, i);
   endfunction

   task automatic send_random_sequence();
      int    kind;
      string body;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         case ($urandom_range(0, 3))
            0:       send_event(16'($urandom), 16'($urandom));
            1:       send_event(16'h0000, 16'($urandom));
            2:       send_event(SCAN_CODE_ESC, 16'($urandom_range(0, 1)));
            default: send_event(16'($urandom_range(0, 24)), 16'h0000);
         endcase
      end else begin
         send_event(SCAN_CODE_ESC, 16'h0000);
         if (kind < 20)
            body = pick("xO[~1A");
         else if (kind < 40)
            body = {"[", pick("ABCDHFPQRSZ")};
         else if (kind < 55)
            body = {"O", pick("ABCDHFPQRSZ~1")};
         else if (kind < 70)
            body = {"[", pick("0123456789"), pick("~~~~~x")};
         else if (kind < 85)
            body = {"[", pick("1212123"), pick("0123456789"), pick("~~~~~;")};
         else begin
            body = "[";
            repeat ($urandom_range(1, 8)) body = {body, pick("0123456789;~ABO[")};
         end
         send_text(body, kind >= 20);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_event(16'hFFFF, 16'hFFFF);
      send_event(16'h0000, 16'h0000);
      send_event(SCAN_CODE_ESC, 16'hFFFF);
      send_event(SCAN_CODE_ESC, 16'h0000);
      send_text("[A", 1'b0);
      send_event(SCAN_CODE_ESC, 16'h0000);
      send_text("OS", 1'b0);
      send_event(SCAN_CODE_ESC, 16'h0000);
      send_text("[2~", 1'b0);
      send_event(SCAN_CODE_ESC, 16'h0000);
      send_text("[24~", 1'b0);
      // escape then an ordinary letter leaves the escape pending
      send_event(SCAN_CODE_ESC, 16'h0000);
      send_text("x", 1'b0);
      send_event(SCAN_CODE_ESC, 16'h0000);
      send_event(16'h0005, 16'h0000);
      drain();

      while (sent < EVENT_TARGET) begin
         send_random_sequence();
         if (!paused_mid && sent >= EVENT_TARGET / 2) begin
            paused_mid = 1'b1;
            drain();
         end
      end
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d key events sent, %0d results checked, %0d escape sequences decoded",
               sent, checked, decoded);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/aekd_pkg.sv
hdl/aekd_step.sv
hdl/ansi_escape_key_decoder.sv
hdl/aekd_checker.sv
dv/key_result_checker.sv
dv/tb.sv
